// ===== sv/ecs_pkg.sv =====
// ---------------------------------------------------------------------------
// ecs_pkg: shared constants, types and helpers for the encoder counter
// Counter width, speed scale, opcodes, register map and the FSM state type.
// ---------------------------------------------------------------------------
package ecs_pkg;

    // pulse counter width (16..64)
    localparam int COUNT_BITS = 32;

    // 60 s/min * 1000 ms/s * 100 centi-rpm per rpm
    localparam int              SCALE_BITS = 23;
    localparam logic [22:0]     SPEED_SCALE = 23'd6000000;

    // dividend = |delta| * scale, divisor = ppr * elapsed ms
    localparam int PROD_W = COUNT_BITS + SCALE_BITS;
    localparam int DEN_W  = 48;
    localparam int CNT_W  = $clog2(PROD_W);

    // input opcodes
    localparam logic [1:0] OP_EDGE    = 2'd0;
    localparam logic [1:0] OP_TICK    = 2'd1;
    localparam logic [1:0] OP_MEASURE = 2'd2;
    localparam logic [1:0] OP_TAKE    = 2'd3;

    // register map
    localparam int         ADDR_W   = 3;
    localparam logic [2:0] ADDR_PPR = 3'd0;

    // saturation limits
    localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_NEG = 32'h8000_0000;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_MUL  = 5'b00010,
        ST_DIV  = 5'b00100,
        ST_SAT  = 5'b01000,
        ST_DONE = 5'b10000
    } state_t;

    // low 32 bits of the sign-extended count
    function automatic logic [31:0] ext32(input logic [COUNT_BITS-1:0] v);
        logic signed [63:0] e;
        e = 64'($signed(v));
        return e[31:0];
    endfunction

endpackage

// ===== sv/encoder_counter_speed_top.sv =====
// ---------------------------------------------------------------------------
// encoder_counter_speed_top: x1 quadrature counter with speed measurement
// One encoder channel: pulse counter, millisecond timebase, delta snapshots
// and a bit-serial speed divider, with a stream in/out and an APB port.
// ---------------------------------------------------------------------------
// Each input beat is one event. Phase A edge, millisecond tick and take-delta
// are handled in the idle state and their result beat is loaded straight into
// the output register when it is free. When it is still held, the result waits
// in the done state and is loaded from there once the output register is free;
// no input is taken meanwhile.
// A measure beat with a non-zero divisor runs the serial datapath: a shift-add
// product over the bits of the 23-bit speed scale, then one step per dividend
// bit (COUNT_BITS + 23) in the restoring divider, then a saturation state and
// the done state. A measure with zero pulses_per_rev or zero elapsed time
// yields speed 0 and goes straight to the done state. The input is taken
// only while the engine is idle; a finished result may still be waiting in
// the output register at that point. Speed is in 0.01 rpm, truncated toward
// zero and saturated to the signed 32-bit range.
// ---------------------------------------------------------------------------
module encoder_counter_speed_top (
    input  logic                          clk,
    input  logic                          rst_n,
    // input stream
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [7:0]                    s_tdata,   // [0] phase_b_level
    input  logic [1:0]                    s_tuser,   // [1:0] opcode
    // result stream
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [95:0]                   m_tdata,   // [31:0] position_count,
                                                     // [63:32] delta_count,
                                                     // [95:64] speed_centi_rpm
    // configuration
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [ecs_pkg::ADDR_W-1:0]    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int CB = ecs_pkg::COUNT_BITS;
    localparam int PW = ecs_pkg::PROD_W;
    localparam int DW = ecs_pkg::DEN_W;
    localparam int NW = ecs_pkg::CNT_W;

    // control and architectural state
    ecs_pkg::state_t   state_reg, state_next;
    logic [CB-1:0]     pulse_count_reg, pulse_count_next;
    logic [CB-1:0]     snap_count_reg, snap_count_next;
    logic [31:0]       ms_time_reg, ms_time_next;
    logic [31:0]       snap_time_reg, snap_time_next;
    logic [31:0]       last_speed_reg, last_speed_next;
    logic [15:0]       ppr_reg;
    logic              m_valid_reg, m_valid_next;

    // serial datapath (no reset needed)
    logic [31:0]       delta_reg, delta_next;
    logic [31:0]       dt_reg, dt_next;
    logic              neg_reg, neg_next;
    logic [CB-1:0]     mag_reg, mag_next;
    logic [DW-1:0]     den_reg, den_next;
    logic [PW-1:0]     prod_reg, prod_next;
    logic [ecs_pkg::SCALE_BITS-1:0] scale_sr_reg, scale_sr_next;
    logic [DW-1:0]     rem_reg, rem_next;
    logic [31:0]       quo_reg, quo_next;
    logic              ovf_reg, ovf_next;
    logic [NW-1:0]     cnt_reg, cnt_next;
    logic [95:0]       m_data_reg, m_data_next;

    logic              out_free;
    logic              accept;
    logic [CB-1:0]     diff;
    logic [DW:0]       trial;
    logic              cfg_wr;

    assign s_tready = (state_reg == ecs_pkg::ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign out_free = !m_valid_reg || m_tready;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign diff  = pulse_count_reg - snap_count_reg;
    // one restoring step: shifted remainder minus divisor, borrow in top bit
    assign trial = {rem_reg, prod_reg[PW-1]} - {1'b0, den_reg};

    // APB: single register, pready tied high
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr == ecs_pkg::ADDR_PPR);
    assign prdata = (paddr == ecs_pkg::ADDR_PPR) ? {16'd0, ppr_reg} : 32'd0;

    always_comb
    begin
        state_next       = state_reg;
        pulse_count_next = pulse_count_reg;
        snap_count_next  = snap_count_reg;
        ms_time_next     = ms_time_reg;
        snap_time_next   = snap_time_reg;
        last_speed_next  = last_speed_reg;
        delta_next       = delta_reg;
        dt_next          = dt_reg;
        neg_next         = neg_reg;
        mag_next         = mag_reg;
        den_next         = den_reg;
        prod_next        = prod_reg;
        scale_sr_next    = scale_sr_reg;
        rem_next         = rem_reg;
        quo_next         = quo_reg;
        ovf_next         = ovf_reg;
        cnt_next         = cnt_reg;
        m_data_next      = m_data_reg;
        m_valid_next     = m_valid_reg && !m_tready;

        case (state_reg)
            ecs_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    delta_next = 32'd0;
                    case (s_tuser)
                        ecs_pkg::OP_EDGE:
                        begin
                            pulse_count_next = s_tdata[0] ? pulse_count_reg + CB'(1)
                                                          : pulse_count_reg - CB'(1);
                        end
                        ecs_pkg::OP_TICK:
                        begin
                            ms_time_next = ms_time_reg + 32'd1;
                        end
                        ecs_pkg::OP_MEASURE:
                        begin
                            delta_next      = ecs_pkg::ext32(diff);
                            snap_count_next = pulse_count_reg;
                            snap_time_next  = ms_time_reg;
                            dt_next         = ms_time_reg - snap_time_reg;
                            neg_next        = diff[CB-1];
                            mag_next        = diff[CB-1] ? CB'(0) - diff : diff;
                            if ((ms_time_reg == snap_time_reg) || (ppr_reg == 16'd0))
                            begin
                                last_speed_next = 32'd0;
                                state_next      = ecs_pkg::ST_DONE;
                            end
                            else
                            begin
                                prod_next     = '0;
                                scale_sr_next = ecs_pkg::SPEED_SCALE;
                                cnt_next      = '0;
                                state_next    = ecs_pkg::ST_MUL;
                            end
                        end
                        ecs_pkg::OP_TAKE:
                        begin
                            delta_next      = ecs_pkg::ext32(diff);
                            snap_count_next = pulse_count_reg;
                        end
                        default:
                        begin
                        end
                    endcase
                    if (s_tuser != ecs_pkg::OP_MEASURE)
                    begin
                        if (out_free)
                        begin
                            m_data_next  = {last_speed_reg, delta_next,
                                            ecs_pkg::ext32(pulse_count_next)};
                            m_valid_next = 1'b1;
                        end
                        else
                        begin
                            state_next = ecs_pkg::ST_DONE;
                        end
                    end
                end
            end

            ecs_pkg::ST_MUL:
            begin
                // shift-add over the scale bits, MSB first
                den_next      = DW'(ppr_reg) * DW'(dt_reg);
                prod_next     = {prod_reg[PW-2:0], 1'b0}
                                + (scale_sr_reg[ecs_pkg::SCALE_BITS-1] ? PW'(mag_reg) : PW'(0));
                scale_sr_next = {scale_sr_reg[ecs_pkg::SCALE_BITS-2:0], 1'b0};
                cnt_next      = cnt_reg + NW'(1);
                if (cnt_reg == NW'(ecs_pkg::SCALE_BITS - 1))
                begin
                    cnt_next   = '0;
                    rem_next   = '0;
                    quo_next   = '0;
                    ovf_next   = 1'b0;
                    state_next = ecs_pkg::ST_DIV;
                end
            end

            ecs_pkg::ST_DIV:
            begin
                // one quotient bit a cycle; bits past 32 only set the overflow flag
                prod_next = {prod_reg[PW-2:0], 1'b0};
                if (!trial[DW])
                begin
                    rem_next = trial[DW-1:0];
                end
                else
                begin
                    rem_next = {rem_reg[DW-2:0], prod_reg[PW-1]};
                end
                quo_next = {quo_reg[30:0], !trial[DW]};
                ovf_next = ovf_reg | quo_reg[31];
                cnt_next = cnt_reg + NW'(1);
                if (cnt_reg == NW'(PW - 1))
                begin
                    state_next = ecs_pkg::ST_SAT;
                end
            end

            ecs_pkg::ST_SAT:
            begin
                if (neg_reg)
                begin
                    last_speed_next = (ovf_reg || (quo_reg > ecs_pkg::SAT_NEG))
                                      ? ecs_pkg::SAT_NEG : 32'd0 - quo_reg;
                end
                else
                begin
                    last_speed_next = (ovf_reg || (quo_reg > ecs_pkg::SAT_POS))
                                      ? ecs_pkg::SAT_POS : quo_reg;
                end
                state_next = ecs_pkg::ST_DONE;
            end

            ecs_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    m_data_next  = {last_speed_reg, delta_reg,
                                    ecs_pkg::ext32(pulse_count_reg)};
                    m_valid_next = 1'b1;
                    state_next   = ecs_pkg::ST_IDLE;
                end
            end

            default:
            begin
                state_next = ecs_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ecs_pkg::ST_IDLE;
            pulse_count_reg <= '0;
            snap_count_reg  <= '0;
            ms_time_reg     <= 32'd0;
            snap_time_reg   <= 32'd0;
            last_speed_reg  <= 32'd0;
            ppr_reg         <= 16'd0;
            m_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            pulse_count_reg <= pulse_count_next;
            snap_count_reg  <= snap_count_next;
            ms_time_reg     <= ms_time_next;
            snap_time_reg   <= snap_time_next;
            last_speed_reg  <= last_speed_next;
            m_valid_reg     <= m_valid_next;
            if (cfg_wr)
            begin
                ppr_reg <= pwdata[15:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        delta_reg    <= delta_next;
        dt_reg       <= dt_next;
        neg_reg      <= neg_next;
        mag_reg      <= mag_next;
        den_reg      <= den_next;
        prod_reg     <= prod_next;
        scale_sr_reg <= scale_sr_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        ovf_reg      <= ovf_next;
        cnt_reg      <= cnt_next;
        m_data_reg   <= m_data_next;
    end

    // measure with a usable divisor must start the serial multiply
    a_measure_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (s_tuser == ecs_pkg::OP_MEASURE) && (ppr_reg != 16'd0)
         && (ms_time_reg != snap_time_reg)) |=> (state_reg == ecs_pkg::ST_MUL))
        else $error("measure did not enter multiply");

    // the divider never runs against a zero divisor
    a_den_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ecs_pkg::ST_SAT) |-> (den_reg != '0))
        else $error("division by zero reached saturation stage");

    // restoring remainder stays below the divisor
    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ecs_pkg::ST_SAT) |-> (rem_reg < den_reg))
        else $error("divider remainder out of range");

    // take-delta re-arms the count snapshot
    a_take_snap: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (s_tuser == ecs_pkg::OP_TAKE)) |=> (snap_count_reg == pulse_count_reg))
        else $error("count snapshot not updated");

endmodule
